/* hdl/lrucmc_pkg.sv */
package lrucmc_pkg;

    // Built sizes
    localparam int WAYS_DEF      = 16;
    localparam int KEY_BITS_DEF  = 12;

    // Field widths
    localparam int ACCESS_KEY_W  = 12;
    localparam int CAP_W         = 5;
    localparam int OUTCOME_W     = 2;
    localparam int STAT_W        = 32;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 136;
    localparam int M_USED_W      = OUTCOME_W + 4 * STAT_W;

    // Configuration port
    localparam int APB_ADDR_W    = 2;
    localparam int APB_DATA_W    = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_HIT        = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_COMPULSORY = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_CAPACITY   = 2'd2;

    // Classification of one access, handed from the lookup side to the counters
    typedef struct packed {
        logic hit;
        logic seen;
    } t_class;

endpackage

/* hdl/lrucmc_seen.sv */
module lrucmc_seen import lrucmc_pkg::*; #(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [KEY_BITS-1:0] i_rd_key,
    input  logic                i_wr_en,
    input  logic [KEY_BITS-1:0] i_wr_key,
    output logic                o_seen,
    output logic                o_clr_busy
);

    localparam int KEY_SPACE = 1 << KEY_BITS;

    logic                r_mem [KEY_SPACE];
    logic                r_rd_bit;
    logic                r_clr_busy;
    logic [KEY_BITS-1:0] r_clr_addr;
    logic                r_last_vld;
    logic [KEY_BITS-1:0] r_last_key;

    // Sweep every key to zero after reset, then set bits as keys retire
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_wr_en) begin
            r_mem[i_wr_key] <= 1'b1;
        end
        if (i_rd_en) begin
            r_rd_bit <= r_mem[i_rd_key];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_last_vld <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_wr_en) begin
                r_last_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_last_key <= i_wr_key;
        end
    end

    // The previous access may have set this key at the edge the read was taken
    assign o_seen     = r_rd_bit | (r_last_vld && (r_last_key == i_wr_key));
    assign o_clr_busy = r_clr_busy;

endmodule

/* hdl/lrucmc_lru.sv */
module lrucmc_lru import lrucmc_pkg::*; #(
    parameter int WAYS     = WAYS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CAP_W-1:0]    i_cap,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic                i_upd,
    output logic                o_hit
);

    localparam int AGE_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    logic [KEY_BITS-1:0] r_keys [WAYS];
    logic [AGE_W-1:0]    r_ages [WAYS];
    logic [FILL_W-1:0]   r_filled;

    logic [CMP_W-1:0]    cap_w;
    logic [CMP_W-1:0]    cap_eff;
    logic                fill;
    logic [WAYS-1:0]     vld;
    logic [WAYS-1:0]     hit_vec;
    logic                hit;
    logic [AGE_W-1:0]    hit_idx;
    logic [AGE_W-1:0]    hit_age;
    logic [AGE_W-1:0]    oldest_age;
    logic [AGE_W-1:0]    victim_idx;
    logic [AGE_W-1:0]    where;
    logic [AGE_W-1:0]    n_ages [WAYS];

    always_comb begin
        cap_w = CMP_W'(i_cap);
        if (cap_w == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_w > CMP_W'(WAYS)) begin
            cap_eff = CMP_W'(WAYS);
        end else begin
            cap_eff = cap_w;
        end
        fill = CMP_W'(r_filled) < cap_eff;
    end

    // Tag match and oldest search; filled keys and filled ages are each distinct
    always_comb begin
        oldest_age = AGE_W'(r_filled - 1'b1);
        hit_idx    = '0;
        hit_age    = '0;
        victim_idx = '0;
        for (int i = 0; i < WAYS; i++) begin
            vld[i]     = FILL_W'(i) < r_filled;
            hit_vec[i] = vld[i] && (r_keys[i] == i_key);
            if (hit_vec[i]) begin
                hit_idx = hit_idx | AGE_W'(i);
                hit_age = hit_age | r_ages[i];
            end
            if (vld[i] && (r_ages[i] == oldest_age)) begin
                victim_idx = victim_idx | AGE_W'(i);
            end
        end
        hit = |hit_vec;
        if (hit) begin
            where = hit_idx;
        end else if (fill) begin
            where = r_filled[AGE_W-1:0];
        end else begin
            where = victim_idx;
        end
    end

    // Age every more recent entry by one, make the touched entry most recent
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            if (AGE_W'(i) == where) begin
                n_ages[i] = '0;
            end else if (vld[i] && (!hit || (r_ages[i] < hit_age))) begin
                n_ages[i] = r_ages[i] + 1'b1;
            end else begin
                n_ages[i] = r_ages[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            for (int i = 0; i < WAYS; i++) begin
                r_ages[i] <= '0;
            end
        end else if (i_upd) begin
            r_ages <= n_ages;
            if (!hit && fill) begin
                r_filled <= r_filled + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd && !hit) begin
            r_keys[where] <= i_key;
        end
    end

    assign o_hit = hit;

endmodule

/* hdl/lrucmc_stats.sv */
module lrucmc_stats import lrucmc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_upd,
    input  t_class               i_cls,
    output logic [OUTCOME_W-1:0] o_outcome,
    output logic [STAT_W-1:0]    o_access,
    output logic [STAT_W-1:0]    o_miss,
    output logic [STAT_W-1:0]    o_comp,
    output logic [STAT_W-1:0]    o_cap
);

    logic [STAT_W-1:0] r_access;
    logic [STAT_W-1:0] r_miss;
    logic [STAT_W-1:0] r_comp;
    logic [STAT_W-1:0] r_cap;
    logic [STAT_W-1:0] n_access;
    logic [STAT_W-1:0] n_miss;
    logic [STAT_W-1:0] n_comp;
    logic [STAT_W-1:0] n_cap;

    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v,
                                                  input logic en);
        sat_inc = (en && (v != '1)) ? v + 1'b1 : v;
    endfunction

    always_comb begin
        n_access = sat_inc(r_access, 1'b1);
        n_miss   = sat_inc(r_miss, !i_cls.hit);
        n_comp   = sat_inc(r_comp, !i_cls.hit && !i_cls.seen);
        n_cap    = sat_inc(r_cap,  !i_cls.hit && i_cls.seen);
        if (i_cls.hit) begin
            o_outcome = OUT_HIT;
        end else if (i_cls.seen) begin
            o_outcome = OUT_CAPACITY;
        end else begin
            o_outcome = OUT_COMPULSORY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access <= '0;
            r_miss   <= '0;
            r_comp   <= '0;
            r_cap    <= '0;
        end else if (i_upd) begin
            r_access <= n_access;
            r_miss   <= n_miss;
            r_comp   <= n_comp;
            r_cap    <= n_cap;
        end
    end

    assign o_access = n_access;
    assign o_miss   = n_miss;
    assign o_comp   = n_comp;
    assign o_cap    = n_cap;

endmodule

/* hdl/lru_cache_miss_classifier_core.sv */
// Fully associative LRU cache model that classifies each access key as a hit,
// a compulsory miss (key never referenced since reset) or a capacity miss, and
// returns saturating 32-bit running totals with every result. One transaction
// in on the slave stream gives exactly one transaction out on the master
// stream. Throughput is one access per cycle while m_tready is high; results
// are registered as their keys leave the input stage. Each key passes an input
// register, where the seen-map read is issued, and then a single pass of tag
// compare and age update over all WAYS entries into the output register; the
// output register lets a new key enter while a result waits. After reset the
// seen map (one bit per key) is swept to zero, one key per cycle, which holds
// s_tready low until all 2**KEY_BITS keys (4096 at the default) are cleared;
// capacity writes are taken during the sweep. The capacity register sits at
// byte address 0: zero acts as one entry and values above WAYS act as WAYS.
module lru_cache_miss_classifier_core import lrucmc_pkg::*; #(
    parameter int WAYS     = WAYS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave stream, tdata: access_key[11:0], zero pad
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Master stream, tdata: outcome[1:0], access_total[33:2], miss_total[65:34],
    // compulsory_total[97:66], capacity_total[129:98], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CAP_W-1:0]     r_cap;
    logic                 r_s1_vld;
    logic [KEY_BITS-1:0]  r_s1_key;
    logic                 r_out_vld;
    logic [M_TDATA_W-1:0] r_out_data;

    logic [KEY_BITS-1:0]  in_key;
    logic                 accept;
    logic                 advance;
    logic                 clr_busy;
    logic                 seen;
    logic                 hit;
    t_class               cls;
    logic [OUTCOME_W-1:0] outcome;
    logic [STAT_W-1:0]    access_total;
    logic [STAT_W-1:0]    miss_total;
    logic [STAT_W-1:0]    comp_total;
    logic [STAT_W-1:0]    cap_total;

    // At most the low KEY_BITS bits of the key take part; a shorter key is zero-extended
    if (KEY_BITS <= ACCESS_KEY_W) begin : g_key_trunc
        assign in_key = s_tdata[KEY_BITS-1:0];
    end else begin : g_key_ext
        assign in_key = {{(KEY_BITS - ACCESS_KEY_W){1'b0}}, s_tdata[ACCESS_KEY_W-1:0]};
    end

    // Configuration: one register; writes land in it at any address, reads
    // return it at address zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr == '0) ? {{(APB_DATA_W - CAP_W){1'b0}}, r_cap} : '0;
    assign pready = 1'b1;

    // Advance the input stage whenever the result register is free or draining
    assign advance  = r_s1_vld && (!r_out_vld || m_tready);
    assign s_tready = !clr_busy && (!r_s1_vld || advance);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (advance) begin
                r_s1_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_key <= in_key;
        end
        if (advance) begin
            r_out_data <= {{(M_TDATA_W - M_USED_W){1'b0}},
                           cap_total, comp_total, miss_total, access_total, outcome};
        end
    end

    lrucmc_seen #(
        .KEY_BITS (KEY_BITS)
    ) u_seen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_key   (in_key),
        .i_wr_en    (advance),
        .i_wr_key   (r_s1_key),
        .o_seen     (seen),
        .o_clr_busy (clr_busy)
    );

    lrucmc_lru #(
        .WAYS     (WAYS),
        .KEY_BITS (KEY_BITS)
    ) u_lru (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (r_cap),
        .i_key   (r_s1_key),
        .i_upd   (advance),
        .o_hit   (hit)
    );

    assign cls.hit  = hit;
    assign cls.seen = seen;

    lrucmc_stats u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (advance),
        .i_cls     (cls),
        .o_outcome (outcome),
        .o_access  (access_total),
        .o_miss    (miss_total),
        .o_comp    (comp_total),
        .o_cap     (cap_total)
    );

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !advance) |=> (r_s1_vld && $stable(r_s1_key)))
        else $error("input stage lost or changed a stalled key");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> m_tvalid)
        else $error("retired access produced no result");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !accept)
        else $error("key accepted during seen-map sweep");
`endif

endmodule
